// File: sv/ecv_pkg.sv
package ecv_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_N - 1);

  // scaled mouse delta, Q.16 degrees
  localparam int SD_W = 28;

  localparam logic signed [29:0] YAW_SPAN  = 30'sd23592960;
  localparam logic signed [25:0] ANG_360   = 26'sd23592960;
  localparam logic signed [25:0] ANG_180   = 26'sd11796480;
  localparam logic signed [25:0] ANG_90    = 26'sd5898240;
  localparam logic signed [22:0] PITCH_MAX = 23'sd2949120;
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

  localparam logic [2:0] REG_INIT_PITCH = 3'd0;
  localparam logic [2:0] REG_INIT_YAW   = 3'd1;
  localparam logic [2:0] REG_START_X    = 3'd2;
  localparam logic [2:0] REG_START_Y    = 3'd3;
  localparam logic [2:0] REG_START_Z    = 3'd4;
  localparam logic [2:0] REG_UP_X       = 3'd5;
  localparam logic [2:0] REG_UP_Y       = 3'd6;
  localparam logic [2:0] REG_UP_Z       = 3'd7;

  typedef struct packed {
    logic signed [SD_W-1:0] dx;
    logic signed [SD_W-1:0] dy;
    logic signed [31:0]     adv;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_YAW, S_CORDIC, S_TRIG, S_FMUL, S_FRONT, S_SQ, S_SQRT, S_DIV,
    S_NORM, S_CROSS, S_CRND, S_UVEC, S_URND, S_DOT, S_DRND, S_EMIT
  } bk_state_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic signed [25:0] atan_q16(input logic [4:0] i);
    logic signed [25:0] r;
    case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/ecv_front.sv
module ecv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_delta_x,
  input  logic signed [15:0]  in_delta_y,
  input  logic signed [31:0]  in_advance_z,
  output ecv_pkg::item_t      push_item,
  output logic                push_valid,
  input  logic                q_full
);

  // round(d * 65536 / 20) as (|d| * 16384 + 2) / 5 by reciprocal
  function automatic logic signed [ecv_pkg::SD_W-1:0] scale_counts(
    input logic signed [15:0] d);
    logic [15:0] mag;
    logic [29:0] n;
    logic [61:0] prod;
    logic signed [ecv_pkg::SD_W-1:0] q;
    mag  = d[15] ? (~d + 16'd1) : d;
    n    = {mag, 14'b0} + 30'd2;
    prod = 62'(n) * 62'(ecv_pkg::RECIP5);
    q    = $signed(prod[61:34]);
    return d[15] ? -q : q;
  endfunction

  logic           st_valid_r, st_valid_nxt;
  ecv_pkg::item_t st_item_r;
  logic           accept, push;

  assign in_stall   = st_valid_r && q_full;
  assign accept     = in_valid && !in_stall;
  assign push       = st_valid_r && !q_full;
  assign push_valid = st_valid_r;
  assign push_item  = st_item_r;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (accept) begin
      st_valid_nxt = 1'b1;
    end else if (push) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
    if (accept) begin
      st_item_r.dx  <= scale_counts(in_delta_x);
      st_item_r.dy  <= scale_counts(in_delta_y);
      st_item_r.adv <= in_advance_z;
    end
  end

endmodule

// File: sv/ecv_fifo.sv
module ecv_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  ecv_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ecv_pkg::item_t head
);

  ecv_pkg::item_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       wr, rd;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign wr        = push_valid && !full;
  assign rd        = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr && !rd) begin
      count_nxt = count_r + 2'd1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
    if (wr) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: sv/ecv_back.sv
module ecv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ecv_pkg::cfg_wr_t   cfg_wr,
  input  logic               q_valid,
  input  ecv_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col_zero,
  output logic signed [31:0] out_col_one,
  output logic signed [31:0] out_col_two,
  output logic signed [31:0] out_col_three,
  output logic               out_last_row
);

  function automatic logic [1:0] nxt1(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0: r = 2'd1;
      2'd1: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nxt2(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      2'd0: r = 2'd2;
      2'd1: r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] rnd_cordic(input logic signed [33:0] v);
    logic signed [33:0] s;
    s = v + 34'sd32768;
    return s[33:16];
  endfunction

  ecv_pkg::bk_state_t state_r, state_nxt;

  logic signed [22:0] pitch_r;
  logic [24:0]        yaw_r;
  logic signed [31:0] eye_r [3];
  logic signed [15:0] up_r [3];
  logic signed [29:0] yw_r;

  // cordic lanes: 0 pitch, 1 yaw
  logic signed [33:0] cx_r [2];
  logic signed [33:0] cy_r [2];
  logic signed [25:0] cz_r [2];
  logic               neg_y_r;
  logic [4:0]         it_r;

  logic signed [17:0] cosp_r, sinp_r, cosy_r, siny_r;
  logic signed [35:0] fp0_r, fp1_r;

  logic signed [22:0] vin_r [3];
  logic signed [55:0] prod_r;
  logic signed [51:0] acc_r;

  logic [45:0] sq_n_r, sq_rt_r, sq_bit_r;
  logic [22:0] len_r;
  logic [37:0] rem_r [3];
  logic [14:0] quo_r [3];
  logic [3:0]  dv_i_r;

  logic signed [15:0] f_r [3];
  logic signed [15:0] s_r [3];
  logic signed [17:0] u_r [3];
  logic signed [31:0] t_r [3];

  logic [1:0] k_r, d_r, row_r;
  logic       j_r, ph_r, nsel_r;

  logic               out_valid_r;
  logic [1:0]         out_row_r;
  logic signed [31:0] out_c0_r, out_c1_r, out_c2_r, out_c3_r;
  logic               out_last_r;

  // control decode
  logic               mac_on, mac_first, mac_last, ld_ok;
  logic signed [22:0] mac_a;
  logic signed [32:0] mac_b;
  logic signed [51:0] acc_sum;
  logic signed [31:0] em_c0, em_c1, em_c2, em_c3;
  logic signed [16:0] neg_f;

  // item intake
  logic signed [28:0] p_sum, p_clamp;
  logic signed [32:0] z_sum;
  logic signed [31:0] z_sat;

  // cordic setup
  logic signed [25:0] ya0, ya1;
  logic               ya_neg;

  // square root step
  logic [45:0] sq_try;

  // rounding of accumulator
  logic signed [51:0] acc_r8, acc_r14;
  logic signed [37:0] dot_w;
  logic signed [31:0] dot_sat;

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_col_zero  = out_c0_r;
  assign out_col_one   = out_c1_r;
  assign out_col_two   = out_c2_r;
  assign out_col_three = out_c3_r;
  assign out_last_row  = out_last_r;

  assign p_sum   = 29'(pitch_r) + 29'(q_item.dy);
  assign p_clamp = (p_sum > 29'(ecv_pkg::PITCH_MAX))  ? 29'(ecv_pkg::PITCH_MAX) :
                   (p_sum < -29'(ecv_pkg::PITCH_MAX)) ? -29'(ecv_pkg::PITCH_MAX) : p_sum;
  assign z_sum   = 33'(eye_r[2]) + 33'(q_item.adv);
  assign z_sat   = (z_sum[32] != z_sum[31]) ?
                   (z_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : z_sum[31:0];

  // bring yaw into the cordic range, negating results past +-90
  always_comb begin
    ya0    = $signed({1'b0, yw_r[24:0]});
    ya1    = (ya0 > ecv_pkg::ANG_180) ? ya0 - ecv_pkg::ANG_360 : ya0;
    ya_neg = 1'b0;
    if (ya1 > ecv_pkg::ANG_90) begin
      ya1    = ya1 - ecv_pkg::ANG_180;
      ya_neg = 1'b1;
    end else if (ya1 < -ecv_pkg::ANG_90) begin
      ya1    = ya1 + ecv_pkg::ANG_180;
      ya_neg = 1'b1;
    end
  end

  assign sq_try  = sq_rt_r + sq_bit_r;
  assign acc_sum = (mac_first ? 52'sd0 : acc_r) + prod_r[51:0];
  assign acc_r8  = acc_r + 52'sd128;
  assign acc_r14 = acc_r + 52'sd8192;
  assign dot_w   = acc_r14[51:14];
  assign dot_sat = (dot_w > 38'sh007FFFFFFF)  ? 32'sh7FFFFFFF :
                   (dot_w < -38'sh0080000000) ? 32'sh80000000 : dot_w[31:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecv_pkg::S_IDLE:   if (q_valid) state_nxt = ecv_pkg::S_YAW;
      ecv_pkg::S_YAW: begin
        if (yw_r >= 30'sd0 && yw_r < ecv_pkg::YAW_SPAN) state_nxt = ecv_pkg::S_CORDIC;
      end
      ecv_pkg::S_CORDIC: if (it_r == ecv_pkg::CORDIC_LAST) state_nxt = ecv_pkg::S_TRIG;
      ecv_pkg::S_TRIG:   state_nxt = ecv_pkg::S_FMUL;
      ecv_pkg::S_FMUL:   state_nxt = ecv_pkg::S_FRONT;
      ecv_pkg::S_FRONT:  state_nxt = ecv_pkg::S_SQ;
      ecv_pkg::S_SQ:     if (mac_last) state_nxt = ecv_pkg::S_SQRT;
      ecv_pkg::S_SQRT:   if (sq_bit_r == 46'd0) state_nxt = ecv_pkg::S_DIV;
      ecv_pkg::S_DIV:    if (dv_i_r == 4'd0) state_nxt = ecv_pkg::S_NORM;
      ecv_pkg::S_NORM:   state_nxt = nsel_r ? ecv_pkg::S_UVEC : ecv_pkg::S_CROSS;
      ecv_pkg::S_CROSS:  if (mac_last) state_nxt = ecv_pkg::S_CRND;
      ecv_pkg::S_CRND:   state_nxt = (k_r == 2'd2) ? ecv_pkg::S_SQ : ecv_pkg::S_CROSS;
      ecv_pkg::S_UVEC:   if (mac_last) state_nxt = ecv_pkg::S_URND;
      ecv_pkg::S_URND:   state_nxt = (k_r == 2'd2) ? ecv_pkg::S_DOT : ecv_pkg::S_UVEC;
      ecv_pkg::S_DOT:    if (mac_last) state_nxt = ecv_pkg::S_DRND;
      ecv_pkg::S_DRND:   state_nxt = (d_r == 2'd2) ? ecv_pkg::S_EMIT : ecv_pkg::S_DOT;
      ecv_pkg::S_EMIT:   if (ld_ok && row_r == 2'd3) state_nxt = ecv_pkg::S_IDLE;
      default:           state_nxt = ecv_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    mac_on    = 1'b0;
    mac_first = 1'b0;
    mac_last  = 1'b0;
    mac_a     = 23'sd0;
    mac_b     = 33'sd0;
    ld_ok     = !out_valid_r || !out_stall;
    neg_f     = -17'(f_r[2]);
    em_c0     = 32'sd0;
    em_c1     = 32'sd0;
    em_c2     = 32'sd0;
    em_c3     = 32'sd0;
    case (state_r)
      ecv_pkg::S_IDLE: q_pop = q_valid;
      ecv_pkg::S_SQ: begin
        mac_on    = 1'b1;
        mac_a     = vin_r[k_r];
        mac_b     = 33'(vin_r[k_r]);
        mac_first = (k_r == 2'd0);
        mac_last  = ph_r && (k_r == 2'd2);
      end
      ecv_pkg::S_CROSS: begin
        mac_on    = 1'b1;
        mac_a     = j_r ? -23'(f_r[nxt2(k_r)]) : 23'(f_r[nxt1(k_r)]);
        mac_b     = j_r ? 33'(up_r[nxt1(k_r)]) : 33'(up_r[nxt2(k_r)]);
        mac_first = !j_r;
        mac_last  = ph_r && j_r;
      end
      ecv_pkg::S_UVEC: begin
        mac_on    = 1'b1;
        mac_a     = j_r ? -23'(s_r[nxt2(k_r)]) : 23'(s_r[nxt1(k_r)]);
        mac_b     = j_r ? 33'(f_r[nxt1(k_r)]) : 33'(f_r[nxt2(k_r)]);
        mac_first = !j_r;
        mac_last  = ph_r && j_r;
      end
      ecv_pkg::S_DOT: begin
        mac_on = 1'b1;
        case (d_r)
          2'd0:    mac_a = -23'(s_r[k_r]);
          2'd1:    mac_a = -23'(u_r[k_r]);
          default: mac_a = 23'(f_r[k_r]);
        endcase
        mac_b     = 33'(eye_r[k_r]);
        mac_first = (k_r == 2'd0);
        mac_last  = ph_r && (k_r == 2'd2);
      end
      ecv_pkg::S_EMIT: begin
        case (row_r)
          2'd0: begin
            em_c0 = {{14{s_r[0][15]}}, s_r[0], 2'b00};
            em_c1 = {{14{s_r[1][15]}}, s_r[1], 2'b00};
            em_c2 = {{14{s_r[2][15]}}, s_r[2], 2'b00};
            em_c3 = t_r[0];
          end
          2'd1: begin
            em_c0 = {{12{u_r[0][17]}}, u_r[0], 2'b00};
            em_c1 = {{12{u_r[1][17]}}, u_r[1], 2'b00};
            em_c2 = {{12{u_r[2][17]}}, u_r[2], 2'b00};
            em_c3 = t_r[1];
          end
          2'd2: begin
            em_c0 = 32'(-17'(f_r[0])) <<< 2;
            em_c1 = 32'(-17'(f_r[1])) <<< 2;
            em_c2 = 32'(neg_f) <<< 2;
            em_c3 = t_r[2];
          end
          default: em_c3 = 32'sd65536;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ecv_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pitch_r     <= 23'sd0;
      yaw_r       <= 25'd0;
      eye_r[0]    <= 32'sd0;
      eye_r[1]    <= 32'sd0;
      eye_r[2]    <= 32'sd0;
      up_r[0]     <= 16'sd0;
      up_r[1]     <= 16'sd16384;
      up_r[2]     <= 16'sd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ecv_pkg::S_EMIT && ld_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          ecv_pkg::REG_INIT_PITCH: pitch_r <= cfg_wr.data[22:0];
          ecv_pkg::REG_INIT_YAW: begin
            if (cfg_wr.data[24:0] >= 25'(ecv_pkg::YAW_SPAN)) begin
              yaw_r <= cfg_wr.data[24:0] - 25'(ecv_pkg::YAW_SPAN);
            end else begin
              yaw_r <= cfg_wr.data[24:0];
            end
          end
          ecv_pkg::REG_START_X: eye_r[0] <= cfg_wr.data;
          ecv_pkg::REG_START_Y: eye_r[1] <= cfg_wr.data;
          ecv_pkg::REG_START_Z: eye_r[2] <= cfg_wr.data;
          ecv_pkg::REG_UP_X:    up_r[0]  <= cfg_wr.data[15:0];
          ecv_pkg::REG_UP_Y:    up_r[1]  <= cfg_wr.data[15:0];
          ecv_pkg::REG_UP_Z:    up_r[2]  <= cfg_wr.data[15:0];
          default: ;
        endcase
      end

      if (state_r == ecv_pkg::S_IDLE && q_valid) begin
        pitch_r  <= p_clamp[22:0];
        eye_r[2] <= z_sat;
      end
      if (state_r == ecv_pkg::S_YAW && yw_r >= 30'sd0 && yw_r < ecv_pkg::YAW_SPAN) begin
        yaw_r <= yw_r[24:0];
      end
    end

    if (state_r == ecv_pkg::S_EMIT && ld_ok) begin
      out_row_r  <= row_r;
      out_c0_r   <= em_c0;
      out_c1_r   <= em_c1;
      out_c2_r   <= em_c2;
      out_c3_r   <= em_c3;
      out_last_r <= (row_r == 2'd3);
      row_r      <= row_r + 2'd1;
    end

    // shared multiply-accumulate, with a multiply phase and an accumulate phase per product
    if (mac_on) begin
      ph_r <= ~ph_r;
      if (!ph_r) begin
        prod_r <= 56'(mac_a) * 56'(mac_b);
      end else begin
        acc_r <= acc_sum;
      end
    end

    case (state_r)
      ecv_pkg::S_IDLE: begin
        yw_r <= $signed({5'b0, yaw_r}) + 30'(q_item.dy - q_item.dy + q_item.dx);
      end
      ecv_pkg::S_YAW: begin
        if (yw_r < 30'sd0) begin
          yw_r <= yw_r + ecv_pkg::YAW_SPAN;
        end else if (yw_r >= ecv_pkg::YAW_SPAN) begin
          yw_r <= yw_r - ecv_pkg::YAW_SPAN;
        end
        cx_r[0] <= ecv_pkg::CORDIC_INV_GAIN;
        cy_r[0] <= 34'sd0;
        cz_r[0] <= 26'(pitch_r);
        cx_r[1] <= ecv_pkg::CORDIC_INV_GAIN;
        cy_r[1] <= 34'sd0;
        cz_r[1] <= ya1;
        neg_y_r <= ya_neg;
        it_r    <= 5'd0;
      end
      ecv_pkg::S_CORDIC: begin
        for (int l = 0; l < 2; l++) begin
          if (cz_r[l] >= 26'sd0) begin
            cx_r[l] <= cx_r[l] - (cy_r[l] >>> it_r);
            cy_r[l] <= cy_r[l] + (cx_r[l] >>> it_r);
            cz_r[l] <= cz_r[l] - ecv_pkg::atan_q16(it_r);
          end else begin
            cx_r[l] <= cx_r[l] + (cy_r[l] >>> it_r);
            cy_r[l] <= cy_r[l] - (cx_r[l] >>> it_r);
            cz_r[l] <= cz_r[l] + ecv_pkg::atan_q16(it_r);
          end
        end
        it_r <= it_r + 5'd1;
      end
      ecv_pkg::S_TRIG: begin
        cosp_r <= rnd_cordic(cx_r[0]);
        sinp_r <= rnd_cordic(cy_r[0]);
        cosy_r <= neg_y_r ? -rnd_cordic(cx_r[1]) : rnd_cordic(cx_r[1]);
        siny_r <= neg_y_r ? -rnd_cordic(cy_r[1]) : rnd_cordic(cy_r[1]);
      end
      ecv_pkg::S_FMUL: begin
        fp0_r <= 36'(cosp_r) * 36'(siny_r);
        fp1_r <= 36'(cosp_r) * 36'(cosy_r);
      end
      ecv_pkg::S_FRONT: begin
        vin_r[0] <= -23'($signed(fp0_r[35:14] + fp0_r[13]));
        vin_r[1] <= -23'(sinp_r);
        vin_r[2] <= -23'($signed(fp1_r[35:14] + fp1_r[13]));
        nsel_r   <= 1'b0;
        k_r      <= 2'd0;
        ph_r     <= 1'b0;
      end
      ecv_pkg::S_SQ: begin
        if (ph_r) begin
          k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        end
        if (mac_last) begin
          sq_n_r   <= acc_sum[45:0];
          sq_rt_r  <= 46'd0;
          sq_bit_r <= 46'd1 << 44;
        end
      end
      ecv_pkg::S_SQRT: begin
        if (sq_bit_r == 46'd0) begin
          len_r  <= sq_rt_r[22:0];
          dv_i_r <= 4'd14;
          for (int l = 0; l < 3; l++) begin
            rem_r[l] <= {1'b0, (vin_r[l][22] ? 23'(-vin_r[l]) : vin_r[l]), 14'b0}
                        + 38'(sq_rt_r[22:1]);
            quo_r[l] <= 15'd0;
          end
        end else begin
          if (sq_n_r >= sq_try) begin
            sq_n_r  <= sq_n_r - sq_try;
            sq_rt_r <= (sq_rt_r >> 1) + sq_bit_r;
          end else begin
            sq_rt_r <= sq_rt_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
        end
      end
      ecv_pkg::S_DIV: begin
        for (int l = 0; l < 3; l++) begin
          if (rem_r[l] >= (38'(len_r) << dv_i_r)) begin
            rem_r[l] <= rem_r[l] - (38'(len_r) << dv_i_r);
            quo_r[l] <= {quo_r[l][13:0], 1'b1};
          end else begin
            quo_r[l] <= {quo_r[l][13:0], 1'b0};
          end
        end
        dv_i_r <= dv_i_r - 4'd1;
      end
      ecv_pkg::S_NORM: begin
        for (int l = 0; l < 3; l++) begin
          if (len_r == 23'd0) begin
            if (nsel_r) s_r[l] <= 16'sd0;
            else        f_r[l] <= 16'sd0;
          end else if (vin_r[l][22]) begin
            if (nsel_r) s_r[l] <= -$signed({1'b0, quo_r[l]});
            else        f_r[l] <= -$signed({1'b0, quo_r[l]});
          end else begin
            if (nsel_r) s_r[l] <= $signed({1'b0, quo_r[l]});
            else        f_r[l] <= $signed({1'b0, quo_r[l]});
          end
        end
        k_r  <= 2'd0;
        j_r  <= 1'b0;
        ph_r <= 1'b0;
      end
      ecv_pkg::S_CROSS, ecv_pkg::S_UVEC: begin
        if (ph_r) begin
          j_r <= ~j_r;
        end
      end
      ecv_pkg::S_CRND: begin
        vin_r[k_r] <= acc_r8[30:8];
        if (k_r == 2'd2) begin
          k_r    <= 2'd0;
          nsel_r <= 1'b1;
        end else begin
          k_r <= k_r + 2'd1;
        end
      end
      ecv_pkg::S_URND: begin
        u_r[k_r] <= acc_r14[31:14];
        d_r      <= 2'd0;
        k_r      <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      ecv_pkg::S_DOT: begin
        if (ph_r) begin
          k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        end
      end
      ecv_pkg::S_DRND: begin
        t_r[d_r] <= dot_sat;
        d_r      <= d_r + 2'd1;
        row_r    <= 2'd0;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/euler_camera_view_matrix.sv
// Euler-angle camera: each input item (mouse deltas and a z step) updates pitch,
// yaw and eye z, then the block returns the four rows of the look-at view matrix
// as four result items, row 0 first, last_row set on row 3. Items are taken into
// a two-deep queue and worked one at a time by a single sequencer, which wraps the
// yaw back by whole turns (at most five), runs the CORDIC_N iterations of the shared
// two-lane CORDIC and then does two normalize passes, each a bit-pair square root
// and three parallel restoring dividers with 15-bit quotients, with the squares,
// cross products and dot terms going through one multiply-accumulate unit. The rows
// then leave at one per cycle while out_stall is low. Configuration writes are always
// ready and take effect at once; write them only while no item is in flight.
module euler_camera_view_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_delta_x,
  input  logic signed [15:0] in_delta_y,
  input  logic signed [31:0] in_advance_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_col_zero,
  output logic signed [31:0] out_col_one,
  output logic signed [31:0] out_col_two,
  output logic signed [31:0] out_col_three,
  output logic               out_last_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  ecv_pkg::item_t   push_item, head;
  ecv_pkg::cfg_wr_t cfg_wr;
  logic             push_valid, q_full, q_pop, q_valid;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  ecv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_delta_x   (in_delta_x),
    .in_delta_y   (in_delta_y),
    .in_advance_z (in_advance_z),
    .push_item    (push_item),
    .push_valid   (push_valid),
    .q_full       (q_full)
  );

  ecv_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (head)
  );

  ecv_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .q_valid       (q_valid),
    .q_item        (head),
    .q_pop         (q_pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_col_zero  (out_col_zero),
    .out_col_one   (out_col_one),
    .out_col_two   (out_col_two),
    .out_col_three (out_col_three),
    .out_last_row  (out_last_row)
  );

endmodule

// File: tb/sv/euler_camera_view_matrix_tb.sv
`timescale 1ns / 100ps

module euler_camera_view_matrix_tb;

  localparam int  IDLE_LIMIT = 40000;
  localparam int  DRAIN_CYCLES = 300;
  localparam longint FULL_TURN = 23592960;
  localparam longint HALF_TURN = 11796480;
  localparam longint QUARTER_TURN = 5898240;
  localparam longint PITCH_CLAMP = 2949120;
  localparam longint INV_GAIN = 652032874;

  typedef longint vec3_t [3];

  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0, c1, c2, c3;
    logic        last;
  } view_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_delta_x = '0;
  logic signed [15:0] in_delta_y = '0;
  logic signed [31:0] in_advance_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_row_index;
  logic signed [31:0] out_col_zero, out_col_one, out_col_two, out_col_three;
  logic               out_last_row;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  view_row_t pending_rows[$];
  int        errors = 0;
  int        snd_idle = 0;
  int        rcv_idle = 0;
  bit        hold_req = 0;
  int        idle_cycles = 0;

  // camera state as the block should hold it
  longint cam_pitch, cam_yaw;
  vec3_t  cam_eye, cam_front, cam_up;

  const longint atan_deg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  euler_camera_view_matrix dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void sin_cos(input longint a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = INV_GAIN;
    y = 0;
    flip = 0;
    a = a % FULL_TURN;
    if (a < 0) a += FULL_TURN;
    if (a > HALF_TURN) a -= FULL_TURN;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1;
    end
    z = a;
    for (int i = 0; i < ecv_pkg::CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_deg[i];
      end else begin
        x += dx; y -= dy; z += atan_deg[i];
      end
    end
    c = round_sh(x, 16);
    s = round_sh(y, 16);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic void refresh_front();
    longint cp, sp, cy, sy;
    sin_cos(cam_pitch, cp, sp);
    sin_cos(cam_yaw, cy, sy);
    cam_front[0] = -round_sh(cp * sy, 14);
    cam_front[1] = -sp;
    cam_front[2] = -round_sh(cp * cy, 14);
  endfunction

  function automatic void unit_vec(input vec3_t c, output vec3_t o);
    longint unsigned sum, len, m, q;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      m = (c[k] < 0) ? -c[k] : c[k];
      sum += m * m;
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        o[k] = 0;
      end else begin
        m = (c[k] < 0) ? -c[k] : c[k];
        q = (m * 16384 + len / 2) / len;
        o[k] = (c[k] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic longint counts_to_deg(longint d);
    longint unsigned m;
    longint q;
    m = (d < 0) ? -d : d;
    q = (m * 16384 + 2) / 5;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint eye_dot(vec3_t v);
    return v[0] * cam_eye[0] + v[1] * cam_eye[1] + v[2] * cam_eye[2];
  endfunction

  function automatic void push_row(int row, vec3_t v, longint t);
    view_row_t r;
    r.row = 2'(row);
    r.c0 = 32'(v[0] * 4);
    r.c1 = 32'(v[1] * 4);
    r.c2 = 32'(v[2] * 4);
    r.c3 = 32'(t);
    r.last = (row == 3);
    pending_rows.push_back(r);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      ecv_pkg::REG_INIT_PITCH: begin
        cam_pitch = longint'($signed(d[22:0]));
        refresh_front();
      end
      ecv_pkg::REG_INIT_YAW: begin
        cam_yaw = longint'(d[24:0]) % FULL_TURN;
        refresh_front();
      end
      ecv_pkg::REG_START_X: cam_eye[0] = longint'($signed(d));
      ecv_pkg::REG_START_Y: cam_eye[1] = longint'($signed(d));
      ecv_pkg::REG_START_Z: cam_eye[2] = longint'($signed(d));
      ecv_pkg::REG_UP_X:    cam_up[0] = longint'($signed(d[15:0]));
      ecv_pkg::REG_UP_Y:    cam_up[1] = longint'($signed(d[15:0]));
      ecv_pkg::REG_UP_Z:    cam_up[2] = longint'($signed(d[15:0]));
      default: ;
    endcase
  endfunction

  function automatic void predict_view(logic signed [15:0] dx, logic signed [15:0] dy,
                                       logic signed [31:0] adv);
    vec3_t f, c, s, u, nf, z;
    longint p;
    p = cam_pitch + counts_to_deg(dy);
    if (p > PITCH_CLAMP) p = PITCH_CLAMP;
    if (p < -PITCH_CLAMP) p = -PITCH_CLAMP;
    cam_pitch = p;
    cam_yaw = (cam_yaw + counts_to_deg(dx)) % FULL_TURN;
    if (cam_yaw < 0) cam_yaw += FULL_TURN;
    refresh_front();
    cam_eye[2] = clip32(cam_eye[2] + adv);
    unit_vec(cam_front, f);
    c[0] = round_sh(f[1] * cam_up[2] - f[2] * cam_up[1], 8);
    c[1] = round_sh(f[2] * cam_up[0] - f[0] * cam_up[2], 8);
    c[2] = round_sh(f[0] * cam_up[1] - f[1] * cam_up[0], 8);
    unit_vec(c, s);
    u[0] = round_sh(s[1] * f[2] - s[2] * f[1], 14);
    u[1] = round_sh(s[2] * f[0] - s[0] * f[2], 14);
    u[2] = round_sh(s[0] * f[1] - s[1] * f[0], 14);
    for (int k = 0; k < 3; k++) begin
      nf[k] = -f[k];
      z[k] = 0;
    end
    push_row(0, s, clip32(round_sh(-eye_dot(s), 14)));
    push_row(1, u, clip32(round_sh(-eye_dot(u), 14)));
    push_row(2, nf, clip32(round_sh(eye_dot(f), 14)));
    push_row(3, z, 65536);
  endfunction

  task automatic send_item(logic signed [15:0] dx, logic signed [15:0] dy,
                           logic signed [31:0] adv);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_delta_x <= dx;
    in_delta_y <= dy;
    in_advance_z <= adv;
    do @(posedge clk); while (in_stall);
    predict_view(dx, dy, adv);
  endtask

  // let every row drain and the sequencer go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_camera(logic [31:0] p, logic [31:0] y, logic [31:0] ex,
                            logic [31:0] ey, logic [31:0] ez, logic [15:0] ux,
                            logic [15:0] uy, logic [15:0] uz);
    settle();
    write_reg(ecv_pkg::REG_INIT_PITCH, p);
    write_reg(ecv_pkg::REG_INIT_YAW, y);
    write_reg(ecv_pkg::REG_START_X, ex);
    write_reg(ecv_pkg::REG_START_Y, ey);
    write_reg(ecv_pkg::REG_START_Z, ez);
    write_reg(ecv_pkg::REG_UP_X, {{16{ux[15]}}, ux});
    write_reg(ecv_pkg::REG_UP_Y, {{16{uy[15]}}, uy});
    write_reg(ecv_pkg::REG_UP_Z, {{16{uz[15]}}, uz});
  endtask

  task automatic test_reset_state();
    send_item(16'sd0, 16'sd0, 32'sd0);
    send_item(16'sd20, -16'sd20, 32'sd65536);
  endtask

  task automatic test_field_extremes();
    send_item(16'sh7fff, 16'sh7fff, 32'sh7fffffff);
    send_item(16'sh8000, 16'sh8000, 32'sh80000000);
    send_item(16'sh8000, 16'sh7fff, 32'sh80000000);
    send_item(16'sh7fff, 16'sh8000, 32'sh7fffffff);
    send_item(16'shffff, 16'shffff, 32'shffffffff);
    send_item(16'sh5555, 16'shaaaa, 32'sh55555555);
    send_item(16'shaaaa, 16'sh5555, 32'shaaaaaaaa);
  endtask

  task automatic test_yaw_wrap();
    set_camera(32'd0, 32'd23592959, 32'd0, 32'd0, 32'd0, 16'sd0, 16'sd16384, 16'sd0);
    send_item(16'sd1, 16'sd0, 32'sd0);
    send_item(-16'sd2, 16'sd0, 32'sd0);
    send_item(16'sd3600, 16'sd0, 32'sd0);
  endtask

  task automatic test_degenerate_up();
    // up along the view axis gives no side vector
    set_camera(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'sd0, 16'sd0, 16'sd16384);
    send_item(16'sd0, 16'sd0, 32'sd0);
    set_camera(32'd0, 32'd0, 32'd100, 32'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd0, 16'sd0, 32'sd0);
  endtask

  task automatic test_pitch_overrange();
    // a loaded pitch beyond the clamp is clamped by the next item
    set_camera(32'h003fffff, 32'd5898240, 32'd0, 32'd0, 32'd0,
               -16'sd16384, 16'sd16384, 16'sd16384);
    send_item(16'sd0, 16'sd0, 32'sd0);
    set_camera(32'hffc00000, 32'd11796480, 32'd0, 32'd0, 32'd0,
               16'sd16384, -16'sd16384, -16'sd16384);
    send_item(16'sd0, 16'sd0, 32'sd0);
  endtask

  task automatic test_translation_sat();
    set_camera(32'd2949120, 32'd17694720, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               16'sd0, 16'sd16384, 16'sd0);
    send_item(16'sd0, 16'sd0, 32'sh7fffffff);
    set_camera(32'hffd30000, 32'd2949120, 32'h80000000, 32'h80000000, 32'h80000000,
               16'sd0, 16'sd16384, 16'sd0);
    send_item(16'sd0, 16'sd0, 32'sh80000000);
  endtask

  task automatic test_random_phase(int n);
    logic signed [15:0] dx, dy;
    logic signed [31:0] adv;
    set_camera($urandom_range(5898240) - 2949120, $urandom_range(23592959),
               $urandom, $urandom, $urandom,
               16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
               16'($urandom_range(32768) - 16384));
    for (int i = 0; i < n; i++) begin
      dx = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(800) - 400);
      dy = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(800) - 400);
      adv = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(400000) - 200000);
      send_item(dx, dy, adv);
    end
  endtask

  task automatic test_backpressure();
    snd_idle = 0;
    rcv_idle = 0;
    settle();
    hold_req = 1;
    for (int i = 0; i < 6; i++) send_item(16'($urandom), 16'($urandom), 32'($urandom));
  endtask

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    static int hold_cnt = 0;
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 1500;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    view_row_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("euler_camera_view_matrix test failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_rows.size() == 0) begin
          $error("unexpected row item %0d", out_row_index);
          errors++;
        end else begin
          e = pending_rows.pop_front();
          if (out_row_index !== e.row) begin
            $error("row_index expected %0d got %0d", e.row, out_row_index);
            errors++;
          end
          if (out_col_zero !== e.c0) begin
            $error("col_zero expected %0d got %0d", $signed(e.c0), out_col_zero);
            errors++;
          end
          if (out_col_one !== e.c1) begin
            $error("col_one expected %0d got %0d", $signed(e.c1), out_col_one);
            errors++;
          end
          if (out_col_two !== e.c2) begin
            $error("col_two expected %0d got %0d", $signed(e.c2), out_col_two);
            errors++;
          end
          if (out_col_three !== e.c3) begin
            $error("col_three expected %0d got %0d", $signed(e.c3), out_col_three);
            errors++;
          end
          if (out_last_row !== e.last) begin
            $error("last_row expected %0d got %0d", e.last, out_last_row);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    cam_pitch = 0;
    cam_yaw = 0;
    cam_eye = '{0, 0, 0};
    cam_front = '{0, 0, -16384};
    cam_up = '{0, 16384, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle = 9;
    rcv_idle = 54;
    test_reset_state();
    test_field_extremes();
    test_yaw_wrap();
    test_degenerate_up();
    test_pitch_overrange();
    test_translation_sat();
    test_random_phase(30);
    snd_idle = 54;
    rcv_idle = 9;
    test_random_phase(30);
    snd_idle = 0;
    rcv_idle = 0;
    test_random_phase(30);
    test_backpressure();
    settle();
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("euler_camera_view_matrix test passed");
    end else begin
      $display("euler_camera_view_matrix test failed");
    end
    $finish;
  end

endmodule
